FILE: design/ntt_polynomial_multiply_unit_defines.svh
// ----------------------------------------------------------------------------
// NTT polynomial multiply unit assertion macros
// Shared helpers for the concurrent checks in the top design file.
// ----------------------------------------------------------------------------
`ifndef NTT_POLYNOMIAL_MULTIPLY_UNIT_DEFINES_SVH
`define NTT_POLYNOMIAL_MULTIPLY_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define NPMU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define NPMU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/npmu_pkg.sv
// ----------------------------------------------------------------------------
// npmu_pkg
// Constants, types and small modular helpers of the NTT polynomial multiply unit.
// ----------------------------------------------------------------------------
package npmu_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_LOG    = 6;
   localparam int COEF_BITS  = 30;
   localparam int ADDR_W     = 6;
   localparam int TW_ADDR_W  = 7;
   localparam int TW_DEPTH   = MAX_POINTS + 1;
   localparam int CNT_W      = 7;
   localparam int STAGE_W    = 3;
   localparam int MUL_STEPS  = COEF_BITS;
   localparam int STEP_W     = 5;

   localparam logic [1:0] CSR_MODULUS  = 2'd0;
   localparam logic [1:0] CSR_ROOT     = 2'd1;
   localparam logic [1:0] CSR_LOG_SIZE = 2'd2;

   localparam logic [COEF_BITS-1:0] MODULUS_RESET  = 30'd998244353;
   localparam logic [COEF_BITS-1:0] ROOT_RESET     = 30'd3;
   localparam logic [2:0]           LOG_SIZE_RESET = 3'd6;
   localparam logic [COEF_BITS-1:0] MODULUS_MIN    = 30'd3;

   typedef struct packed {
      logic                 start;
      logic [COEF_BITS-1:0] x;
      logic [COEF_BITS-1:0] y;
      logic [COEF_BITS-1:0] m;
   } mm_req_type;

   typedef struct packed {
      logic                 done;
      logic [COEF_BITS-1:0] res;
   } mm_rsp_type;

   typedef enum logic [30:0] {
      S_IDLE   = 31'd1 << 0,
      S_LD_A   = 31'd1 << 1,
      S_LD_B   = 31'd1 << 2,
      S_PW_RED = 31'd1 << 3,
      S_PW_CHK = 31'd1 << 4,
      S_PW_MR  = 31'd1 << 5,
      S_PW_SQ  = 31'd1 << 6,
      S_TW_MUL = 31'd1 << 7,
      S_RS_RD  = 31'd1 << 8,
      S_RS_CAP = 31'd1 << 9,
      S_RS_A   = 31'd1 << 10,
      S_RS_B   = 31'd1 << 11,
      S_BR_RD0 = 31'd1 << 12,
      S_BR_RD1 = 31'd1 << 13,
      S_BR_CAP = 31'd1 << 14,
      S_BR_WR0 = 31'd1 << 15,
      S_BR_WR1 = 31'd1 << 16,
      S_BF_RD0 = 31'd1 << 17,
      S_BF_RD1 = 31'd1 << 18,
      S_BF_CAP = 31'd1 << 19,
      S_BF_MA  = 31'd1 << 20,
      S_BF_MB  = 31'd1 << 21,
      S_BF_WR0 = 31'd1 << 22,
      S_BF_WR1 = 31'd1 << 23,
      S_PM_RD  = 31'd1 << 24,
      S_PM_CAP = 31'd1 << 25,
      S_PM_MUL = 31'd1 << 26,
      S_EM_RD  = 31'd1 << 27,
      S_EM_CAP = 31'd1 << 28,
      S_EM_MUL = 31'd1 << 29,
      S_EM_OUT = 31'd1 << 30
   } state_type;

   function automatic logic [COEF_BITS-1:0] add_mod(input logic [COEF_BITS-1:0] a,
                                                    input logic [COEF_BITS-1:0] b,
                                                    input logic [COEF_BITS-1:0] m);
      logic [COEF_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[COEF_BITS-1:0];
   endfunction

   function automatic logic [COEF_BITS-1:0] sub_mod(input logic [COEF_BITS-1:0] a,
                                                    input logic [COEF_BITS-1:0] b,
                                                    input logic [COEF_BITS-1:0] m);
      logic [COEF_BITS:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + ({1'b0, m} - {1'b0, b});
      end
      return s[COEF_BITS-1:0];
   endfunction

   // Bit-reversed index within a transform of 2**lg points.
   function automatic logic [ADDR_W-1:0] rev_index(input logic [ADDR_W-1:0] i,
                                                   input logic [STAGE_W-1:0] lg);
      logic [ADDR_W-1:0] r;
      for (int b = 0; b < ADDR_W; b++) begin
         r[ADDR_W-1-b] = i[b];
      end
      return r >> (STAGE_W'(MAX_LOG) - lg);
   endfunction

endpackage

FILE: design/ntt_polynomial_multiply_unit.sv
// ----------------------------------------------------------------------------
// ntt_polynomial_multiply_unit
// Cyclic convolution of two coefficient vectors modulo a prime by NTT.
// ----------------------------------------------------------------------------
// Each accepted word loads one coefficient of each vector; both coefficients
// are reduced through the single bit-serial modular multiplier. After n
// words or a word marked last, the unit forms the twiddles and n^-1 by
// square-and-multiply, reduces the stores, runs two forward transforms, the
// pointwise product and the inverse transform in three RAMs, then sends the
// n result words with their index. The run takes up to 120 modular
// multiplies for the two exponentiations plus 2n + n + n + n + 1.5 n log2(n)
// for the rest. Words are not taken during a run; the last result may still
// wait in the output register while the next word is taken. Unloaded entries
// read as zero through the load count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "ntt_polynomial_multiply_unit_defines.svh"

module ntt_polynomial_multiply_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [npmu_pkg::COEF_BITS-1:0]  req_a_coef,
   input  logic [npmu_pkg::COEF_BITS-1:0]  req_b_coef,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [npmu_pkg::COEF_BITS-1:0]  rsp_product_coef,
   output logic [npmu_pkg::ADDR_W-1:0]     rsp_coef_index,
   output logic                            rsp_final_res,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [npmu_pkg::COEF_BITS-1:0]  csr_data
);

   localparam int CW = npmu_pkg::COEF_BITS;
   localparam int AW = npmu_pkg::ADDR_W;
   localparam int NW = npmu_pkg::CNT_W;
   localparam int SW = npmu_pkg::STAGE_W;

   // Configuration registers.
   logic [CW-1:0] pm_ff, pr_ff;
   logic [2:0]    tls_ff;

   npmu_pkg::state_type state_ff, state_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] stage_ff, stage_in;
   logic          last_ff, last_in;
   logic          inv_ff, inv_in;
   logic          pow_sel_ff, pow_sel_in;
   logic [CW-1:0] pw_base_ff, pw_base_in;
   logic [CW-1:0] pw_res_ff, pw_res_in;
   logic [CW-1:0] pw_exp_ff, pw_exp_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] invlen_ff, invlen_in;
   logic [CW-1:0] ua_ff, ua_in, ub_ff, ub_in;
   logic [CW-1:0] va_ff, va_in, vb_ff, vb_in;
   logic [CW-1:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] hold_ff, hold_in;
   logic          mm_start_ff, mm_start_in;
   logic [CW-1:0] mm_x_ff, mm_x_in, mm_y_ff, mm_y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_coef_ff, rsp_coef_in;
   logic [AW-1:0] rsp_index_ff, rsp_index_in;
   logic          rsp_final_ff, rsp_final_in;

   npmu_pkg::mm_req_type mm_req;
   npmu_pkg::mm_rsp_type mm_rsp;

   logic                 a_we, b_we, tw_we;
   logic [AW-1:0]        a_waddr, b_waddr, a_raddr, b_raddr;
   logic [CW-1:0]        a_wdata, b_wdata, a_rdata, b_rdata, tw_wdata, tw_rdata;
   logic [npmu_pkg::TW_ADDR_W-1:0] tw_waddr, tw_raddr;

   logic [CW-1:0] m_eff;
   logic [SW-1:0] lg;
   logic [NW-1:0] n;
   logic [NW-1:0] half, lo, hi, lpart, z, twi;
   logic [AW-1:0] rev;
   logic          out_free, rsp_load;

   always_comb begin
      m_eff = (pm_ff < npmu_pkg::MODULUS_MIN) ? npmu_pkg::MODULUS_MIN : pm_ff;
      if (tls_ff == 3'd0) begin
         lg = SW'(1);
      end else if (tls_ff > SW'(npmu_pkg::MAX_LOG)) begin
         lg = SW'(npmu_pkg::MAX_LOG);
      end else begin
         lg = tls_ff;
      end
      n     = NW'(1) << lg;
      half  = NW'(1) << (stage_ff - SW'(1));
      lpart = idx_ff & (half - NW'(1));
      lo    = ((idx_ff >> (stage_ff - SW'(1))) << stage_ff) | lpart;
      hi    = lo | half;
      z     = lpart << (lg - stage_ff);
      twi   = inv_ff ? (n - z) : z;
      rev   = npmu_pkg::rev_index(idx_ff[AW-1:0], lg);
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != npmu_pkg::S_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      stage_in     = stage_ff;
      last_in      = last_ff;
      inv_in       = inv_ff;
      pow_sel_in   = pow_sel_ff;
      pw_base_in   = pw_base_ff;
      pw_res_in    = pw_res_ff;
      pw_exp_in    = pw_exp_ff;
      step_in      = step_ff;
      invlen_in    = invlen_ff;
      ua_in        = ua_ff;
      ub_in        = ub_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      w_in         = w_ff;
      hold_in      = hold_ff;
      mm_start_in  = 1'b0;
      mm_x_in      = mm_x_ff;
      mm_y_in      = mm_y_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_coef_in  = rsp_coef_ff;
      rsp_index_in = rsp_index_ff;
      rsp_final_in = rsp_final_ff;
      a_we = 1'b0;  a_waddr = idx_ff[AW-1:0];  a_wdata = mm_rsp.res;
      b_we = 1'b0;  b_waddr = idx_ff[AW-1:0];  b_wdata = mm_rsp.res;
      a_raddr  = idx_ff[AW-1:0];
      b_raddr  = idx_ff[AW-1:0];
      tw_we    = 1'b0;
      tw_waddr = idx_ff;
      tw_wdata = mm_rsp.res;
      tw_raddr = twi;

      unique case (state_ff)
         npmu_pkg::S_IDLE: begin
            if (req_valid) begin
               if (cnt_ff < n) begin
                  mm_start_in = 1'b1;
                  mm_x_in     = CW'(1);
                  mm_y_in     = req_a_coef;
                  hold_in     = req_b_coef;
                  last_in     = req_last;
                  state_in    = npmu_pkg::S_LD_A;
               end else begin
                  // The length shrank below the load count: drop the word and run.
                  pow_sel_in  = 1'b0;
                  pw_exp_in   = (m_eff - CW'(1)) >> lg;
                  pw_res_in   = CW'(1);
                  mm_start_in = 1'b1;
                  mm_x_in     = CW'(1);
                  mm_y_in     = pr_ff;
                  state_in    = npmu_pkg::S_PW_RED;
               end
            end
         end
         npmu_pkg::S_LD_A: begin
            a_waddr = cnt_ff[AW-1:0];
            if (mm_rsp.done) begin
               a_we        = 1'b1;
               mm_start_in = 1'b1;
               mm_x_in     = CW'(1);
               mm_y_in     = hold_ff;
               state_in    = npmu_pkg::S_LD_B;
            end
         end
         npmu_pkg::S_LD_B: begin
            b_waddr = cnt_ff[AW-1:0];
            if (mm_rsp.done) begin
               b_we   = 1'b1;
               cnt_in = cnt_ff + NW'(1);
               if ((cnt_ff + NW'(1)) < n && !last_ff) begin
                  state_in = npmu_pkg::S_IDLE;
               end else begin
                  pow_sel_in  = 1'b0;
                  pw_exp_in   = (m_eff - CW'(1)) >> lg;
                  pw_res_in   = CW'(1);
                  mm_start_in = 1'b1;
                  mm_x_in     = CW'(1);
                  mm_y_in     = pr_ff;
                  state_in    = npmu_pkg::S_PW_RED;
               end
            end
         end
         npmu_pkg::S_PW_RED: begin
            if (mm_rsp.done) begin
               pw_base_in = mm_rsp.res;
               state_in   = npmu_pkg::S_PW_CHK;
            end
         end
         npmu_pkg::S_PW_CHK: begin
            if (pw_exp_ff == '0) begin
               if (!pow_sel_ff) begin
                  step_in     = pw_res_ff;
                  pow_sel_in  = 1'b1;
                  pw_exp_in   = m_eff - CW'(2);
                  pw_res_in   = CW'(1);
                  mm_start_in = 1'b1;
                  mm_x_in     = CW'(1);
                  mm_y_in     = CW'(n);
                  state_in    = npmu_pkg::S_PW_RED;
               end else begin
                  invlen_in   = pw_res_ff;
                  tw_we       = 1'b1;
                  tw_waddr    = '0;
                  tw_wdata    = CW'(1);
                  idx_in      = NW'(1);
                  mm_start_in = 1'b1;
                  mm_x_in     = CW'(1);
                  mm_y_in     = step_ff;
                  state_in    = npmu_pkg::S_TW_MUL;
               end
            end else if (pw_exp_ff[0]) begin
               mm_start_in = 1'b1;
               mm_x_in     = pw_res_ff;
               mm_y_in     = pw_base_ff;
               state_in    = npmu_pkg::S_PW_MR;
            end else begin
               mm_start_in = 1'b1;
               mm_x_in     = pw_base_ff;
               mm_y_in     = pw_base_ff;
               state_in    = npmu_pkg::S_PW_SQ;
            end
         end
         npmu_pkg::S_PW_MR: begin
            if (mm_rsp.done) begin
               pw_res_in   = mm_rsp.res;
               mm_start_in = 1'b1;
               mm_x_in     = pw_base_ff;
               mm_y_in     = pw_base_ff;
               state_in    = npmu_pkg::S_PW_SQ;
            end
         end
         npmu_pkg::S_PW_SQ: begin
            if (mm_rsp.done) begin
               pw_base_in = mm_rsp.res;
               pw_exp_in  = pw_exp_ff >> 1;
               state_in   = npmu_pkg::S_PW_CHK;
            end
         end
         npmu_pkg::S_TW_MUL: begin
            if (mm_rsp.done) begin
               tw_we = 1'b1;
               if (idx_ff == n) begin
                  idx_in   = '0;
                  state_in = npmu_pkg::S_RS_RD;
               end else begin
                  idx_in      = idx_ff + NW'(1);
                  mm_start_in = 1'b1;
                  mm_x_in     = mm_rsp.res;
                  mm_y_in     = step_ff;
               end
            end
         end
         npmu_pkg::S_RS_RD: begin
            state_in = npmu_pkg::S_RS_CAP;
         end
         npmu_pkg::S_RS_CAP: begin
            // Entries past the load count hold stale data and stand for zero.
            ua_in       = (idx_ff < cnt_ff) ? a_rdata : '0;
            ub_in       = (idx_ff < cnt_ff) ? b_rdata : '0;
            mm_start_in = 1'b1;
            mm_x_in     = CW'(1);
            mm_y_in     = (idx_ff < cnt_ff) ? a_rdata : '0;
            state_in    = npmu_pkg::S_RS_A;
         end
         npmu_pkg::S_RS_A: begin
            if (mm_rsp.done) begin
               a_we        = 1'b1;
               mm_start_in = 1'b1;
               mm_x_in     = CW'(1);
               mm_y_in     = ub_ff;
               state_in    = npmu_pkg::S_RS_B;
            end
         end
         npmu_pkg::S_RS_B: begin
            if (mm_rsp.done) begin
               b_we = 1'b1;
               if (idx_ff == n - NW'(1)) begin
                  idx_in   = '0;
                  inv_in   = 1'b0;
                  state_in = npmu_pkg::S_BR_RD0;
               end else begin
                  idx_in   = idx_ff + NW'(1);
                  state_in = npmu_pkg::S_RS_RD;
               end
            end
         end
         npmu_pkg::S_BR_RD0: begin
            if (idx_ff[AW-1:0] > rev) begin
               state_in = npmu_pkg::S_BR_RD1;
            end else if (idx_ff == n - NW'(1)) begin
               idx_in   = '0;
               stage_in = SW'(1);
               state_in = npmu_pkg::S_BF_RD0;
            end else begin
               idx_in = idx_ff + NW'(1);
            end
         end
         npmu_pkg::S_BR_RD1: begin
            a_raddr  = rev;
            b_raddr  = rev;
            ua_in    = a_rdata;
            ub_in    = b_rdata;
            state_in = npmu_pkg::S_BR_CAP;
         end
         npmu_pkg::S_BR_CAP: begin
            va_in    = a_rdata;
            vb_in    = b_rdata;
            state_in = npmu_pkg::S_BR_WR0;
         end
         npmu_pkg::S_BR_WR0: begin
            a_we     = 1'b1;
            b_we     = 1'b1;
            a_wdata  = va_ff;
            b_wdata  = vb_ff;
            state_in = npmu_pkg::S_BR_WR1;
         end
         npmu_pkg::S_BR_WR1: begin
            a_we    = 1'b1;
            b_we    = 1'b1;
            a_waddr = rev;
            b_waddr = rev;
            a_wdata = ua_ff;
            b_wdata = ub_ff;
            if (idx_ff == n - NW'(1)) begin
               idx_in   = '0;
               stage_in = SW'(1);
               state_in = npmu_pkg::S_BF_RD0;
            end else begin
               idx_in   = idx_ff + NW'(1);
               state_in = npmu_pkg::S_BR_RD0;
            end
         end
         npmu_pkg::S_BF_RD0: begin
            a_raddr  = lo[AW-1:0];
            b_raddr  = lo[AW-1:0];
            state_in = npmu_pkg::S_BF_RD1;
         end
         npmu_pkg::S_BF_RD1: begin
            a_raddr  = hi[AW-1:0];
            b_raddr  = hi[AW-1:0];
            ua_in    = a_rdata;
            ub_in    = b_rdata;
            w_in     = tw_rdata;
            state_in = npmu_pkg::S_BF_CAP;
         end
         npmu_pkg::S_BF_CAP: begin
            va_in       = a_rdata;
            vb_in       = b_rdata;
            mm_start_in = 1'b1;
            mm_x_in     = a_rdata;
            mm_y_in     = w_ff;
            state_in    = npmu_pkg::S_BF_MA;
         end
         npmu_pkg::S_BF_MA: begin
            if (mm_rsp.done) begin
               ta_in = mm_rsp.res;
               if (!inv_ff) begin
                  mm_start_in = 1'b1;
                  mm_x_in     = vb_ff;
                  mm_y_in     = w_ff;
                  state_in    = npmu_pkg::S_BF_MB;
               end else begin
                  state_in = npmu_pkg::S_BF_WR0;
               end
            end
         end
         npmu_pkg::S_BF_MB: begin
            if (mm_rsp.done) begin
               tb_in    = mm_rsp.res;
               state_in = npmu_pkg::S_BF_WR0;
            end
         end
         npmu_pkg::S_BF_WR0: begin
            a_we     = 1'b1;
            b_we     = 1'b1;
            a_waddr  = lo[AW-1:0];
            b_waddr  = lo[AW-1:0];
            a_wdata  = npmu_pkg::add_mod(ua_ff, ta_ff, m_eff);
            b_wdata  = npmu_pkg::add_mod(ub_ff, tb_ff, m_eff);
            state_in = npmu_pkg::S_BF_WR1;
         end
         npmu_pkg::S_BF_WR1: begin
            a_we    = 1'b1;
            b_we    = 1'b1;
            a_waddr = hi[AW-1:0];
            b_waddr = hi[AW-1:0];
            a_wdata = npmu_pkg::sub_mod(ua_ff, ta_ff, m_eff);
            b_wdata = npmu_pkg::sub_mod(ub_ff, tb_ff, m_eff);
            if (idx_ff == (n >> 1) - NW'(1)) begin
               idx_in = '0;
               if (stage_ff == lg) begin
                  state_in = inv_ff ? npmu_pkg::S_EM_RD : npmu_pkg::S_PM_RD;
               end else begin
                  stage_in = stage_ff + SW'(1);
                  state_in = npmu_pkg::S_BF_RD0;
               end
            end else begin
               idx_in   = idx_ff + NW'(1);
               state_in = npmu_pkg::S_BF_RD0;
            end
         end
         npmu_pkg::S_PM_RD: begin
            state_in = npmu_pkg::S_PM_CAP;
         end
         npmu_pkg::S_PM_CAP: begin
            mm_start_in = 1'b1;
            mm_x_in     = a_rdata;
            mm_y_in     = b_rdata;
            state_in    = npmu_pkg::S_PM_MUL;
         end
         npmu_pkg::S_PM_MUL: begin
            if (mm_rsp.done) begin
               // The product overwrites the first vector for the inverse pass.
               a_we = 1'b1;
               if (idx_ff == n - NW'(1)) begin
                  idx_in   = '0;
                  inv_in   = 1'b1;
                  state_in = npmu_pkg::S_BR_RD0;
               end else begin
                  idx_in   = idx_ff + NW'(1);
                  state_in = npmu_pkg::S_PM_RD;
               end
            end
         end
         npmu_pkg::S_EM_RD: begin
            state_in = npmu_pkg::S_EM_CAP;
         end
         npmu_pkg::S_EM_CAP: begin
            mm_start_in = 1'b1;
            mm_x_in     = a_rdata;
            mm_y_in     = invlen_ff;
            state_in    = npmu_pkg::S_EM_MUL;
         end
         npmu_pkg::S_EM_MUL: begin
            if (mm_rsp.done) begin
               ta_in    = mm_rsp.res;
               state_in = npmu_pkg::S_EM_OUT;
            end
         end
         npmu_pkg::S_EM_OUT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_coef_in  = ta_ff;
               rsp_index_in = idx_ff[AW-1:0];
               rsp_final_in = (idx_ff == n - NW'(1));
               if (idx_ff == n - NW'(1)) begin
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = npmu_pkg::S_IDLE;
               end else begin
                  idx_in   = idx_ff + NW'(1);
                  state_in = npmu_pkg::S_EM_RD;
               end
            end
         end
         default: begin
            state_in = npmu_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff        <= npmu_pkg::MODULUS_RESET;
         pr_ff        <= npmu_pkg::ROOT_RESET;
         tls_ff       <= npmu_pkg::LOG_SIZE_RESET;
         state_ff     <= npmu_pkg::S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         stage_ff     <= SW'(1);
         inv_ff       <= 1'b0;
         pow_sel_ff   <= 1'b0;
         invlen_ff    <= '0;
         mm_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               npmu_pkg::CSR_MODULUS:  pm_ff  <= csr_data;
               npmu_pkg::CSR_ROOT:     pr_ff  <= csr_data;
               npmu_pkg::CSR_LOG_SIZE: tls_ff <= csr_data[2:0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         stage_ff     <= stage_in;
         inv_ff       <= inv_in;
         pow_sel_ff   <= pow_sel_in;
         invlen_ff    <= invlen_in;
         mm_start_ff  <= mm_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      pw_base_ff   <= pw_base_in;
      pw_res_ff    <= pw_res_in;
      pw_exp_ff    <= pw_exp_in;
      step_ff      <= step_in;
      ua_ff        <= ua_in;
      ub_ff        <= ub_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      w_ff         <= w_in;
      hold_ff      <= hold_in;
      mm_x_ff      <= mm_x_in;
      mm_y_ff      <= mm_y_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_index_ff <= rsp_index_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign mm_req.start = mm_start_ff;
   assign mm_req.x     = mm_x_ff;
   assign mm_req.y     = mm_y_ff;
   assign mm_req.m     = m_eff;

   npmu_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   npmu_ram #(.WIDTH(CW), .DEPTH(npmu_pkg::MAX_POINTS)) u_first_store (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   npmu_ram #(.WIDTH(CW), .DEPTH(npmu_pkg::MAX_POINTS)) u_second_store (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   npmu_ram #(.WIDTH(CW), .DEPTH(npmu_pkg::TW_DEPTH)) u_twiddle_table (
      .clock   (clock),
      .wr_en   (tw_we),
      .wr_addr (tw_waddr),
      .wr_data (tw_wdata),
      .rd_addr (tw_raddr),
      .rd_data (tw_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_product_coef = rsp_coef_ff;
   assign rsp_coef_index   = rsp_index_ff;
   assign rsp_final_res    = rsp_final_ff;

   `NPMU_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= NW'(npmu_pkg::MAX_POINTS), "load count beyond store depth")
   `NPMU_ASSERT_NEXT(a_final_idle, clock, reset, rsp_load && rsp_final_in, (state_ff == npmu_pkg::S_IDLE) && (cnt_ff == '0), "final word did not return to idle")
   `NPMU_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == npmu_pkg::S_EM_OUT, "result word raised outside emission")
   `NPMU_ASSERT_SAME(a_mul_idle, clock, reset, mm_rsp.done, state_ff != npmu_pkg::S_IDLE, "multiplier finished with nobody waiting")

endmodule

FILE: design/npmu_ram.sv
// ----------------------------------------------------------------------------
// npmu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npmu_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/npmu_mulmod.sv
// ----------------------------------------------------------------------------
// npmu_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module npmu_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  npmu_pkg::mm_req_type   mm_req,
   output npmu_pkg::mm_rsp_type   mm_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [npmu_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [npmu_pkg::COEF_BITS-1:0]   r_ff, r_in;
   logic [npmu_pkg::COEF_BITS-1:0]   x_ff, x_in;
   logic [npmu_pkg::COEF_BITS-1:0]   y_ff, y_in;
   logic [npmu_pkg::COEF_BITS-1:0]   m_ff, m_in;
   logic [npmu_pkg::COEF_BITS-1:0]   dbl;

   // The multiplicand must already be reduced; the multiplier may be any value,
   // since Horner accumulation over its bits reduces as it goes.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      dbl     = npmu_pkg::add_mod(r_ff, r_ff, m_ff);
      if (mm_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         r_in    = '0;
         x_in    = mm_req.x;
         y_in    = mm_req.y;
         m_in    = mm_req.m;
      end else if (busy_ff) begin
         r_in = y_ff[npmu_pkg::COEF_BITS-1] ? npmu_pkg::add_mod(dbl, x_ff, m_ff) : dbl;
         y_in = y_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == npmu_pkg::STEP_W'(npmu_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      r_ff    <= r_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      m_ff    <= m_in;
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.res  = r_ff;

endmodule

FILE: dv/tb_ntt_polynomial_multiply_unit.sv
// ----------------------------------------------------------------------------
// tb_ntt_polynomial_multiply_unit
// Drives coefficient pairs through the NTT multiply unit under several
// modulus, root and length settings, predicts each cyclic convolution with
// a direct software transform, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   logic [29:0] coef;
   logic [5:0]  index;
   logic        final_res;
} conv_word_t;

class conv_scoreboard;
   logic [29:0]      modulus = npmu_pkg::MODULUS_RESET;
   logic [29:0]      root = npmu_pkg::ROOT_RESET;
   logic [2:0]       log_size = npmu_pkg::LOG_SIZE_RESET;
   longint unsigned  first_vec[64];
   longint unsigned  second_vec[64];
   longint unsigned  twiddle[65];
   longint unsigned  inv_len;
   int               loaded;
   conv_word_t       pending[$];
   int               errors;

   function void write_reg(logic [1:0] index, logic [29:0] data);
      case (index)
         npmu_pkg::CSR_MODULUS: modulus = data;
         npmu_pkg::CSR_ROOT: root = data;
         npmu_pkg::CSR_LOG_SIZE: log_size = data[2:0];
         default: ;
      endcase
   endfunction

   function longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                     longint unsigned m);
      return ((x % m) * (y % m)) % m;
   endfunction

   function longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                     longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = mod_mul(r, b, m);
         b = mod_mul(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function void ntt(inout longint unsigned v[64], input int n, input int lg,
                     input longint unsigned m, input bit inv);
      longint unsigned t, u, w, tmp;
      int r;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < lg; b++)
            if ((i >> b) & 1) r |= 1 << (lg - 1 - b);
         if (i > r) begin
            tmp = v[i]; v[i] = v[r]; v[r] = tmp;
         end
      end
      for (int len = 2; len <= n; len = len << 1)
         for (int j = 0; j < n; j += len)
            for (int l = 0; l < len / 2; l++) begin
               w = twiddle[inv ? n - (n / len) * l : (n / len) * l];
               t = mod_mul(v[j + l + len / 2], w, m);
               u = v[j + l];
               v[j + l + len / 2] = (u >= t) ? u - t : u + (m - t);
               v[j + l] = (u + t >= m) ? u + t - m : u + t;
            end
      if (inv)
         for (int i = 0; i < n; i++) v[i] = mod_mul(v[i], inv_len, m);
   endfunction

   // Loads one pair unless the store is full; on the word that ends loading, queues the whole product.
   function void note_word(logic [29:0] a, logic [29:0] b, logic last);
      longint unsigned m, step;
      longint unsigned prod[64];
      int n, lg;
      conv_word_t w;
      m = (modulus < 3) ? 3 : modulus;
      lg = (log_size < 1) ? 1 : log_size;
      if (lg > 6) lg = 6;
      n = 1 << lg;
      if (loaded < n) begin
         first_vec[loaded] = a % m;
         second_vec[loaded] = b % m;
         loaded++;
      end
      if (loaded < n && !last) return;
      step = mod_pow(root, (m - 1) / n, m);
      inv_len = mod_pow(n, m - 2, m);
      twiddle[0] = 1 % m;
      for (int i = 1; i <= n; i++) twiddle[i] = mod_mul(twiddle[i - 1], step, m);
      for (int i = 0; i < n; i++) begin
         first_vec[i] = first_vec[i] % m;
         second_vec[i] = second_vec[i] % m;
      end
      ntt(first_vec, n, lg, m, 1'b0);
      ntt(second_vec, n, lg, m, 1'b0);
      for (int i = 0; i < 64; i++)
         prod[i] = (i < n) ? mod_mul(first_vec[i], second_vec[i], m) : 0;
      ntt(prod, n, lg, m, 1'b1);
      for (int i = 0; i < n; i++) begin
         w.coef = prod[i][29:0];
         w.index = i[5:0];
         w.final_res = (i == n - 1);
         pending.push_back(w);
      end
      for (int i = 0; i < 64; i++) begin
         first_vec[i] = 0;
         second_vec[i] = 0;
      end
      loaded = 0;
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_word(logic [29:0] coef, logic [5:0] index, logic fin);
      conv_word_t e;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result coef=%0d index=%0d", coef, index));
         return;
      end
      e = pending.pop_front();
      if (coef !== e.coef)
         report($sformatf("index %0d coef %0d, want %0d", e.index, coef, e.coef));
      if (index !== e.index)
         report($sformatf("index %0d, want %0d", index, e.index));
      if (fin !== e.final_res)
         report($sformatf("index %0d final %0b, want %0b", e.index, fin, e.final_res));
   endtask
endclass

module tb_ntt_polynomial_multiply_unit;
   localparam int CYCLE_LIMIT = 60000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [29:0] req_a_coef = '0;
   logic [29:0] req_b_coef = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [29:0] rsp_product_coef;
   logic [5:0]  rsp_coef_index;
   logic        rsp_final_res;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [29:0] csr_data = '0;

   conv_scoreboard sb = new();
   int  cycles;
   int  stall_left;
   int  words_sent;
   bit  quiet;

   ntt_polynomial_multiply_unit i_dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: check accepted words and stall in random bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_word(rsp_product_coef, rsp_coef_index, rsp_final_res);
         if (stall_left > 0) stall_left--;
         else if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
         rsp_stall <= (stall_left > 0);
      end
   end

   task automatic send_word(logic [29:0] a, logic [29:0] b, logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_coef <= a;
      req_b_coef <= b;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note_word(a, b, last);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [29:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_reg(index, data);
   endtask

   task automatic configure(logic [29:0] p, logic [29:0] g, logic [2:0] lg);
      drain();
      write_csr(npmu_pkg::CSR_MODULUS, p);
      write_csr(npmu_pkg::CSR_ROOT, g);
      write_csr(npmu_pkg::CSR_LOG_SIZE, lg);
   endtask

   function automatic logic [29:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return '0;
         default: return 30'($urandom());
      endcase
   endfunction

   initial begin
      logic [29:0] primes[8] = '{998244353, 469762049, 7340033, 65537, 257, 97, 17, 13};
      logic [29:0] roots[8]  = '{3, 3, 3, 3, 3, 5, 3, 2};
      logic [2:0]  lg;
      int          pick, n, len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, full length, ended at once by a last mark.
      send_word('1, '1, 1'b1);
      configure(17, 3, 2);
      send_word('0, '1, 1'b0);
      send_word(30'd16, 30'd17, 1'b0);
      send_word('1, 30'd1, 1'b0);
      send_word(30'h2AAAAAAA, 30'h15555555, 1'b0);
      send_word(30'd5, 30'd7, 1'b0);
      send_word(30'd9, 30'd3, 1'b1);
      // Length register zero saturates to two points, seven caps at 64.
      configure(257, 3, 0);
      send_word(30'd256, 30'd255, 1'b0);
      send_word(30'd1, 30'd2, 1'b0);
      configure(998244353, 3, 7);
      send_word(30'd12345, 30'd678, 1'b1);
      // Modulus below three is used as three.
      configure(1, 2, 1);
      send_word(30'd4, 30'd5, 1'b0);
      send_word(30'd7, 30'd8, 1'b0);
      // Composite modulus at the top of the range.
      configure('1, 30'h3FFFFFFE, 3);
      send_word('1, 30'h1234567, 1'b1);
      // Settings changed mid-load, then the length shrunk below the count.
      configure(97, 5, 3);
      send_word(30'd100, 30'd200, 1'b0);
      send_word(30'd300, 30'd400, 1'b0);
      send_word(30'd96, 30'd95, 1'b0);
      configure(257, 3, 1);
      send_word(30'd11, 30'd22, 1'b0);
      // Pause until every result is in, then resume.
      drain();

      while (words_sent < 400) begin
         if (words_sent >= 340) quiet = 1'b1;
         pick = $urandom_range(0, 7);
         case ($urandom_range(0, 9))
            0: lg = 3'($urandom_range(1, 2));
            1: lg = 3'($urandom_range(5, 6));
            default: lg = 3'($urandom_range(3, 4));
         endcase
         if (primes[pick] < 100 && lg > 2 && pick != 5) lg = 2;
         if (pick == 5 && lg > 5) lg = 5;
         if ($urandom_range(0, 9) == 0) configure(30'($urandom()), 30'($urandom()), lg);
         else configure(primes[pick], roots[pick], lg);
         n = 1 << lg;
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
            for (int i = 0; i < len && words_sent < 400; i++)
               send_word(rand_coef(), rand_coef(), (i == len - 1) && (len < n));
         end
      end
      quiet = 1'b1;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
